@@ rtl/cppp_pkg.sv @@
// shared types and constants for the capsule pair penetration penalty block
package cppp_pkg;

	localparam int ACC_W = 144;
	localparam int MB_W = 72;
	localparam logic [16:0] ONE_Q16 = 17'd65536;

	typedef enum logic [1:0] {
		UOP_MUL,
		UOP_DIV,
		UOP_SQRT
	} uop_t;

	typedef struct packed {
		logic start;
		uop_t op;
	} unit_req_t;

endpackage

@@ rtl/cppp_unit.sv @@
// shared iterative unit: shift-add multiply, clamped fraction divide, integer square root
module cppp_unit import cppp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  unit_req_t               req,
	input  logic signed [ACC_W-1:0] opa,
	input  logic signed [ACC_W-1:0] opb,
	output logic                    done,
	output logic signed [ACC_W-1:0] result
);

	localparam logic [5:0] DIV_STEPS = 6'd16;
	localparam logic [5:0] SQRT_STEPS = 6'd32;

	typedef enum logic [1:0] {
		U_IDLE = 2'b01,
		U_RUN  = 2'b10
	} ustate_t;

	ustate_t            state_q;
	uop_t               op_q;
	logic [ACC_W-1:0]   x_q, y_q, r_q;
	logic [5:0]         cnt_q;
	logic               neg_q;
	logic               done_q;
	logic signed [ACC_W-1:0] res_q;

	logic [ACC_W-1:0] amag, bmag;
	logic [ACC_W-1:0] rem2, sq_t, q_next, s_next;
	logic             div_ge, sq_ge;

	assign amag = opa[ACC_W-1] ? ACC_W'(-opa) : ACC_W'(opa);
	assign bmag = opb[ACC_W-1] ? ACC_W'(-opb) : ACC_W'(opb);

	assign rem2 = r_q << 1;
	assign div_ge = rem2 >= x_q;
	assign q_next = {y_q[ACC_W-2:0], div_ge};
	assign sq_t = y_q + x_q;
	assign sq_ge = r_q >= sq_t;
	assign s_next = sq_ge ? ((y_q >> 1) + x_q) : (y_q >> 1);

	assign done = done_q;
	assign result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				U_IDLE: begin
					if (req.start) begin
						if (req.op == UOP_DIV && (opa[ACC_W-1] || opa == '0 || opa >= opb)) begin
							done_q <= 1'b1;
						end else begin
							state_q <= U_RUN;
						end
					end
				end
				U_RUN: begin
					case (op_q)
						UOP_MUL: begin
							if (y_q == '0) begin
								done_q <= 1'b1;
								state_q <= U_IDLE;
							end
						end
						default: begin
							if (cnt_q == 6'd1) begin
								done_q <= 1'b1;
								state_q <= U_IDLE;
							end
						end
					endcase
				end
				default: state_q <= U_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == U_IDLE && req.start) begin
			op_q <= req.op;
			case (req.op)
				UOP_MUL: begin
					x_q <= amag;
					y_q <= ACC_W'(bmag[MB_W-1:0]);
					r_q <= '0;
					neg_q <= opa[ACC_W-1] ^ opb[ACC_W-1];
				end
				UOP_DIV: begin
					x_q <= ACC_W'(opb);
					y_q <= '0;
					r_q <= ACC_W'(opa);
					cnt_q <= DIV_STEPS;
					if (opa[ACC_W-1] || opa == '0) begin
						res_q <= '0;
					end else if (opa >= opb) begin
						res_q <= ACC_W'(ONE_Q16);
					end
				end
				default: begin
					x_q <= ACC_W'(64'h4000_0000_0000_0000);
					y_q <= '0;
					r_q <= ACC_W'(opa[63:0]);
					cnt_q <= SQRT_STEPS;
				end
			endcase
		end else if (state_q == U_RUN) begin
			case (op_q)
				UOP_MUL: begin
					if (y_q == '0) begin
						res_q <= neg_q ? -$signed(r_q) : $signed(r_q);
					end else begin
						if (y_q[0]) begin
							r_q <= r_q + x_q;
						end
						x_q <= x_q << 1;
						y_q <= y_q >> 1;
					end
				end
				UOP_DIV: begin
					r_q <= div_ge ? (rem2 - x_q) : rem2;
					y_q <= q_next;
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd1) begin
						res_q <= $signed(q_next);
					end
				end
				default: begin
					if (sq_ge) begin
						r_q <= r_q - sq_t;
					end
					y_q <= s_next;
					x_q <= x_q >> 2;
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd1) begin
						res_q <= $signed(s_next);
					end
				end
			endcase
		end
	end

endmodule

@@ rtl/capsule_pair_penetration_penalty.sv @@
// top level: capsule table, pair sequencer, penalty accumulation and result register
//
// channel   direction  handshake            payload
// in        input      in_valid/in_ready    opcode, indices, origin, dir, radii, last_pair
// out       output     out_valid/out_ready  is_pair, params, distance, overlap, penalty, totals
// cfg       input      cfg_we               cfg_wdata (penalty_weight)
//
// a load goes straight to S_FIN; a pair's run time is set by the bit-serial shared
// multiplier, which steps through the bits of the second operand for each of 41
// products, plus three divides and a square root.
// in_ready is high only while the sequencer is idle; a pending result waits in the
// output register; the next transaction is still accepted and waits in S_FIN for it.
// reset clears control state and the accumulator and sets the weight to one; the table
// is not cleared.
module capsule_pair_penetration_penalty import cppp_pkg::*; #(
	parameter int CAPSULE_CAPACITY = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               opcode,
	input  logic [5:0]         capsule_index,
	input  logic [5:0]         other_index,
	input  logic signed [31:0] origin_x,
	input  logic signed [31:0] origin_y,
	input  logic signed [31:0] origin_z,
	input  logic signed [31:0] dir_x,
	input  logic signed [31:0] dir_y,
	input  logic signed [31:0] dir_z,
	input  logic [30:0]        radius_start,
	input  logic [30:0]        radius_end,
	input  logic               last_pair,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               is_pair,
	output logic [16:0]        param_a,
	output logic [16:0]        param_b,
	output logic [31:0]        distance,
	output logic signed [32:0] overlap,
	output logic               contact,
	output logic [62:0]        penalty,
	output logic [62:0]        total_error,
	output logic               is_total,
	input  logic               cfg_we,
	input  logic [31:0]        cfg_wdata
);

	localparam int AW = (CAPSULE_CAPACITY > 1) ? $clog2(CAPSULE_CAPACITY) : 1;
	localparam int ENTRY_W = 254;
	localparam int PD_W = 68;
	localparam int DD_W = 67;
	localparam int DIFF_W = 52;
	localparam int D2_W = 104;
	localparam logic [62:0] MAX63 = '1;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_ISSUE = 4'b0010,
		S_WAIT  = 4'b0100,
		S_FIN   = 4'b1000
	} state_t;

	typedef enum logic [1:0] {
		WB_NONE,
		WB_SET,
		WB_ADD,
		WB_SUB
	} wb_t;

	typedef enum logic [5:0] {
		MD_PD0X, MD_PD0Y, MD_PD0Z, MD_PD1X, MD_PD1Y, MD_PD1Z,
		MD_D00X, MD_D00Y, MD_D00Z, MD_D11X, MD_D11Y, MD_D11Z,
		MD_D01X, MD_D01Y, MD_D01Z, MD_DET1, MD_DET2, MD_NUM1, MD_NUM2, MD_DIV1,
		MD_P2M, MD_P2S, MD_DIV2, MD_P3M, MD_P3S, MD_DIV3,
		MD_DXA, MD_DXB, MD_DXC, MD_DXS, MD_DYA, MD_DYB, MD_DYC, MD_DYS,
		MD_DZA, MD_DZB, MD_DZC, MD_DZS, MD_SQRT,
		MD_RSA, MD_REA, MD_RSB, MD_REB, MD_OV, MD_OVSQ, MD_PEN, MD_DONE
	} step_t;

	state_t state_q;
	step_t  pc_q;
	logic   out_valid_q;
	logic [62:0] err_q;
	logic [31:0] weight_q;

	logic [ENTRY_W-1:0] mem_q [CAPSULE_CAPACITY];
	logic [ENTRY_W-1:0] rd_a_q, rd_b_q;
	logic [AW-1:0]      wrap_tab [64];

	logic is_pair_q, last_q;
	logic signed [ACC_W-1:0] acc_q, det_q;
	logic signed [PD_W-1:0]  pd0_q, pd1_q;
	logic signed [DD_W-1:0]  d00_q, d11_q, d01_q;
	logic [16:0]             t0_q, t1_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic [D2_W-1:0]         dist2_q;
	logic [31:0]             dist_q, radius_q;
	logic signed [32:0]      ov_q;
	logic [64:0]             ov2_q;
	logic [62:0]             pen_q;

	logic               o_is_pair_q, o_contact_q, o_is_total_q;
	logic [16:0]        o_param_a_q, o_param_b_q;
	logic [31:0]        o_distance_q;
	logic signed [32:0] o_overlap_q;
	logic [62:0]        o_penalty_q, o_total_q;

	logic signed [31:0] a_ox, a_oy, a_oz, a_dx, a_dy, a_dz;
	logic signed [31:0] b_ox, b_oy, b_oz, b_dx, b_dy, b_dz;
	logic [30:0]        a_rs, a_re, b_rs, b_re;
	logic signed [32:0] px, py, pz;

	logic signed [ACC_W-1:0] opa, opb, acc_next, u_res;
	uop_t      uop;
	wb_t       wmode;
	logic      use_unit, u_done, in_fire, out_fire, fin_go, contact_w;
	unit_req_t u_req;
	logic [63:0] sum_w;
	logic [62:0] sum_sat;

	for (genvar gi = 0; gi < 64; gi++) begin : g_wrap
		assign wrap_tab[gi] = AW'(gi % CAPSULE_CAPACITY);
	end

	assign in_ready = state_q == S_IDLE;
	assign in_fire = in_valid && in_ready;
	assign out_fire = out_valid_q && out_ready;
	assign fin_go = state_q == S_FIN && (!out_valid_q || out_ready);

	assign {a_re, a_rs, a_dz, a_dy, a_dx, a_oz, a_oy, a_ox} = rd_a_q;
	assign {b_re, b_rs, b_dz, b_dy, b_dx, b_oz, b_oy, b_ox} = rd_b_q;
	assign px = {b_ox[31], b_ox} - {a_ox[31], a_ox};
	assign py = {b_oy[31], b_oy} - {a_oy[31], a_oy};
	assign pz = {b_oz[31], b_oz} - {a_oz[31], a_oz};

	assign contact_w = dist_q != '0 && !ov_q[32] && ov_q != '0;
	assign sum_w = {1'b0, err_q} + {1'b0, pen_q};
	assign sum_sat = sum_w[63] ? MAX63 : sum_w[62:0];

	always_ff @(posedge clk) begin
		if (in_fire && !opcode) begin
			mem_q[wrap_tab[capsule_index]] <= {radius_end, radius_start, dir_z, dir_y, dir_x,
				origin_z, origin_y, origin_x};
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && opcode) begin
			rd_a_q <= mem_q[wrap_tab[capsule_index]];
			rd_b_q <= mem_q[wrap_tab[other_index]];
		end
	end

	always_comb begin
		opa = '0;
		opb = '0;
		uop = UOP_MUL;
		wmode = WB_NONE;
		use_unit = 1'b1;
		unique case (pc_q)
			MD_PD0X: begin opa = ACC_W'(px); opb = ACC_W'(a_dx); wmode = WB_SET; end
			MD_PD0Y: begin opa = ACC_W'(py); opb = ACC_W'(a_dy); wmode = WB_ADD; end
			MD_PD0Z: begin opa = ACC_W'(pz); opb = ACC_W'(a_dz); wmode = WB_ADD; end
			MD_PD1X: begin opa = ACC_W'(px); opb = ACC_W'(b_dx); wmode = WB_SET; end
			MD_PD1Y: begin opa = ACC_W'(py); opb = ACC_W'(b_dy); wmode = WB_ADD; end
			MD_PD1Z: begin opa = ACC_W'(pz); opb = ACC_W'(b_dz); wmode = WB_ADD; end
			MD_D00X: begin opa = ACC_W'(a_dx); opb = ACC_W'(a_dx); wmode = WB_SET; end
			MD_D00Y: begin opa = ACC_W'(a_dy); opb = ACC_W'(a_dy); wmode = WB_ADD; end
			MD_D00Z: begin opa = ACC_W'(a_dz); opb = ACC_W'(a_dz); wmode = WB_ADD; end
			MD_D11X: begin opa = ACC_W'(b_dx); opb = ACC_W'(b_dx); wmode = WB_SET; end
			MD_D11Y: begin opa = ACC_W'(b_dy); opb = ACC_W'(b_dy); wmode = WB_ADD; end
			MD_D11Z: begin opa = ACC_W'(b_dz); opb = ACC_W'(b_dz); wmode = WB_ADD; end
			MD_D01X: begin opa = ACC_W'(a_dx); opb = ACC_W'(b_dx); wmode = WB_SET; end
			MD_D01Y: begin opa = ACC_W'(a_dy); opb = ACC_W'(b_dy); wmode = WB_ADD; end
			MD_D01Z: begin opa = ACC_W'(a_dz); opb = ACC_W'(b_dz); wmode = WB_ADD; end
			MD_DET1: begin opa = ACC_W'(d00_q); opb = ACC_W'(d11_q); wmode = WB_SET; end
			MD_DET2: begin opa = ACC_W'(d01_q); opb = ACC_W'(d01_q); wmode = WB_SUB; end
			MD_NUM1: begin opa = ACC_W'(pd0_q); opb = ACC_W'(d11_q); wmode = WB_SET; end
			MD_NUM2: begin opa = ACC_W'(pd1_q); opb = ACC_W'(d01_q); wmode = WB_SUB; end
			MD_DIV1: begin opa = acc_q; opb = det_q; uop = UOP_DIV; end
			MD_P2M:  begin opa = ACC_W'(d01_q); opb = ACC_W'(t0_q); wmode = WB_SET; end
			MD_P2S:  begin opa = ACC_W'(pd1_q); opb = ACC_W'(ONE_Q16); wmode = WB_SUB; end
			MD_DIV2: begin opa = acc_q; opb = ACC_W'(d11_q) << 16; uop = UOP_DIV; end
			MD_P3M:  begin opa = ACC_W'(d01_q); opb = ACC_W'(t1_q); wmode = WB_SET; end
			MD_P3S:  begin opa = ACC_W'(pd0_q); opb = ACC_W'(ONE_Q16); wmode = WB_ADD; end
			MD_DIV3: begin opa = acc_q; opb = ACC_W'(d00_q) << 16; uop = UOP_DIV; end
			MD_DXA:  begin opa = ACC_W'(a_dx); opb = ACC_W'(t0_q); wmode = WB_SET; end
			MD_DXB:  begin opa = ACC_W'(b_dx); opb = ACC_W'(t1_q); wmode = WB_SUB; end
			MD_DXC:  begin opa = ACC_W'(px); opb = ACC_W'(ONE_Q16); wmode = WB_SUB; end
			MD_DYA:  begin opa = ACC_W'(a_dy); opb = ACC_W'(t0_q); wmode = WB_SET; end
			MD_DYB:  begin opa = ACC_W'(b_dy); opb = ACC_W'(t1_q); wmode = WB_SUB; end
			MD_DYC:  begin opa = ACC_W'(py); opb = ACC_W'(ONE_Q16); wmode = WB_SUB; end
			MD_DZA:  begin opa = ACC_W'(a_dz); opb = ACC_W'(t0_q); wmode = WB_SET; end
			MD_DZB:  begin opa = ACC_W'(b_dz); opb = ACC_W'(t1_q); wmode = WB_SUB; end
			MD_DZC:  begin opa = ACC_W'(pz); opb = ACC_W'(ONE_Q16); wmode = WB_SUB; end
			MD_DXS, MD_DYS, MD_DZS: begin opa = ACC_W'(diff_q); opb = ACC_W'(diff_q); end
			MD_SQRT: begin opa = ACC_W'(dist2_q[95:32]); uop = UOP_SQRT; end
			MD_RSA:  begin opa = ACC_W'(a_rs); opb = ACC_W'(ONE_Q16 - t0_q); wmode = WB_SET; end
			MD_REA:  begin opa = ACC_W'(a_re); opb = ACC_W'(t0_q); wmode = WB_ADD; end
			MD_RSB:  begin opa = ACC_W'(b_rs); opb = ACC_W'(ONE_Q16 - t1_q); wmode = WB_ADD; end
			MD_REB:  begin opa = ACC_W'(b_re); opb = ACC_W'(t1_q); wmode = WB_ADD; end
			MD_OVSQ: begin opa = ACC_W'(ov_q); opb = ACC_W'(ov_q); wmode = WB_SET; end
			MD_PEN:  begin opa = ACC_W'(ov2_q); opb = ACC_W'(weight_q); wmode = WB_SET; end
			default: use_unit = 1'b0;
		endcase
	end

	always_comb begin
		case (wmode)
			WB_SET:  acc_next = u_res;
			WB_ADD:  acc_next = acc_q + u_res;
			WB_SUB:  acc_next = acc_q - u_res;
			default: acc_next = acc_q;
		endcase
	end

	assign u_req.start = state_q == S_ISSUE && use_unit;
	assign u_req.op = uop;

	cppp_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (u_req),
		.opa    (opa),
		.opb    (opb),
		.done   (u_done),
		.result (u_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q <= MD_PD0X;
			out_valid_q <= 1'b0;
			err_q <= '0;
			weight_q <= 32'd65536;
		end else begin
			if (cfg_we) begin
				weight_q <= cfg_wdata;
			end
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						pc_q <= MD_PD0X;
						state_q <= opcode ? S_ISSUE : S_FIN;
					end
				end
				S_ISSUE: begin
					if (pc_q == MD_DONE) begin
						state_q <= S_FIN;
					end else if (!use_unit) begin
						pc_q <= step_t'(pc_q + 6'd1);
					end else begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (u_done) begin
						pc_q <= step_t'(pc_q + 6'd1);
						state_q <= S_ISSUE;
					end
				end
				S_FIN: begin
					if (fin_go) begin
						state_q <= S_IDLE;
						if (is_pair_q) begin
							err_q <= last_q ? '0 : sum_sat;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			is_pair_q <= opcode;
			last_q <= last_pair;
			t1_q <= '0;
			dist2_q <= '0;
		end
		if (state_q == S_ISSUE && pc_q == MD_OV) begin
			ov_q <= $signed({1'b0, radius_q}) - $signed({1'b0, dist_q});
		end
		if (state_q == S_WAIT && u_done) begin
			acc_q <= acc_next;
			case (pc_q)
				MD_PD0Z: pd0_q <= acc_next[PD_W-1:0];
				MD_PD1Z: pd1_q <= acc_next[PD_W-1:0];
				MD_D00Z: d00_q <= acc_next[DD_W-1:0];
				MD_D11Z: d11_q <= acc_next[DD_W-1:0];
				MD_D01Z: d01_q <= acc_next[DD_W-1:0];
				MD_DET2: det_q <= acc_next;
				MD_DIV1: t0_q <= (!det_q[ACC_W-1] && det_q != '0) ? u_res[16:0] : '0;
				MD_DIV2: t1_q <= (d11_q != '0) ? u_res[16:0] : '0;
				MD_DIV3: begin
					if (d00_q != '0) begin
						t0_q <= u_res[16:0];
					end
				end
				MD_DXC, MD_DYC, MD_DZC: diff_q <= acc_next[DIFF_W-1:0];
				MD_DXS, MD_DYS, MD_DZS: dist2_q <= dist2_q + u_res[D2_W-1:0];
				MD_SQRT: dist_q <= (|dist2_q[D2_W-1:96]) ? '1 : u_res[31:0];
				MD_REB: radius_q <= acc_next[47:16];
				MD_OVSQ: ov2_q <= acc_next[64:0];
				MD_PEN: begin
					if (!contact_w) begin
						pen_q <= '0;
					end else if (|acc_next[ACC_W-1:95]) begin
						pen_q <= MAX63;
					end else begin
						pen_q <= acc_next[94:32];
					end
				end
				default: ;
			endcase
		end
		if (fin_go) begin
			o_is_pair_q <= is_pair_q;
			o_param_a_q <= is_pair_q ? t0_q : '0;
			o_param_b_q <= is_pair_q ? t1_q : '0;
			o_distance_q <= is_pair_q ? dist_q : '0;
			o_overlap_q <= is_pair_q ? ov_q : '0;
			o_contact_q <= is_pair_q && contact_w;
			o_penalty_q <= is_pair_q ? pen_q : '0;
			o_total_q <= is_pair_q ? sum_sat : '0;
			o_is_total_q <= is_pair_q && last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign is_pair = o_is_pair_q;
	assign param_a = o_param_a_q;
	assign param_b = o_param_b_q;
	assign distance = o_distance_q;
	assign overlap = o_overlap_q;
	assign contact = o_contact_q;
	assign penalty = o_penalty_q;
	assign total_error = o_total_q;
	assign is_total = o_is_total_q;

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		u_done |-> state_q == S_WAIT)
		else $error("unit finished outside the wait state");

	a_pair_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && opcode |=> state_q == S_ISSUE && pc_q == MD_PD0X)
		else $error("pair transaction did not start the sequence");

	a_param_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> o_param_a_q <= ONE_Q16 && o_param_b_q <= ONE_Q16)
		else $error("segment parameter out of range");

	a_no_contact_no_penalty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !o_contact_q |-> o_penalty_q == '0)
		else $error("penalty without contact");

endmodule

@@ tb/sv/tb_capsule_pair_penetration_penalty.sv @@
// testbench for capsule_pair_penetration_penalty: random and directed transactions checked against a local predictor
`timescale 1ns / 100ps

module tb_capsule_pair_penetration_penalty;
	import cppp_pkg::*;

	localparam int CAP = 64;
	localparam logic [62:0] MAX63 = {63{1'b1}};
	localparam int IDLE_LIMIT = 20000;
	localparam bit OP_LOAD = 1'b0;
	localparam bit OP_PAIR = 1'b1;

	typedef struct {
		logic               op;
		logic [5:0]         ia;
		logic [5:0]         ib;
		logic signed [31:0] ox, oy, oz, dx, dy, dz;
		logic [30:0]        rs, re;
		logic               last;
		bit                 drain;
		int                 gap;
	} capsule_txn_t;

	typedef struct {
		logic               is_pair;
		logic [16:0]        ta, tb;
		logic [31:0]        dist_v;
		logic [32:0]        ov;
		logic               contact;
		logic [62:0]        pen, total;
		logic               is_total;
	} penalty_res_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic out_valid;
	logic out_ready = 0;
	logic cfg_we = 0;
	logic [31:0] cfg_wdata = 0;
	capsule_txn_t cur = '{default: 0};

	logic is_pair, contact, is_total;
	logic [16:0] param_a, param_b;
	logic [31:0] distance;
	logic signed [32:0] overlap;
	logic [62:0] penalty, total_error;

	capsule_txn_t pend_q[$];
	penalty_res_t expect_q[$];
	int errors = 0;
	int tx_gap = 0;
	int rx_wait = 0;
	int rx_hold = 0;
	int rx_count = 0;
	int idle_cycles = 0;

	// predictor state
	logic signed [31:0] cap_ox[CAP], cap_oy[CAP], cap_oz[CAP];
	logic signed [31:0] cap_dx[CAP], cap_dy[CAP], cap_dz[CAP];
	logic [30:0] cap_rs[CAP], cap_re[CAP];
	logic [62:0] err_acc = 0;
	logic [31:0] weight = 32'd65536;
	bit loaded[CAP];

	capsule_pair_penetration_penalty u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(cur.op), .capsule_index(cur.ia), .other_index(cur.ib),
		.origin_x(cur.ox), .origin_y(cur.oy), .origin_z(cur.oz),
		.dir_x(cur.dx), .dir_y(cur.dy), .dir_z(cur.dz),
		.radius_start(cur.rs), .radius_end(cur.re), .last_pair(cur.last),
		.out_valid(out_valid), .out_ready(out_ready),
		.is_pair(is_pair), .param_a(param_a), .param_b(param_b),
		.distance(distance), .overlap(overlap), .contact(contact),
		.penalty(penalty), .total_error(total_error), .is_total(is_total),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic signed [255:0] dot3(logic signed [255:0] a0, a1, a2, b0, b1, b2);
		return a0 * b0 + a1 * b1 + a2 * b2;
	endfunction

	function automatic logic [16:0] clamp_ratio(logic signed [255:0] num, logic signed [255:0] den);
		logic signed [255:0] q;
		if (num <= 0)
			return 17'd0;
		if (num >= den)
			return ONE_Q16;
		q = (num <<< 16) / den;
		return q[16:0];
	endfunction

	function automatic logic [63:0] floor_sqrt(logic [63:0] u);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > u)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (u >= res + bitv) begin
				u = u - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic penalty_res_t predict_penalty(capsule_txn_t t);
		penalty_res_t r;
		int a, b;
		logic signed [255:0] px, py, pz, pd0, pd1, d00, d11, d01, det, num;
		logic signed [255:0] wt0, wt1, fx, fy, fz, dist2;
		logic [16:0] t0, t1;
		logic [31:0] dist_w;
		logic [63:0] rsum, radius, ov2;
		logic signed [63:0] ov;
		logic [127:0] prod;
		logic [63:0] sum;
		logic [62:0] pen;
		r = '{default: 0};
		a = t.ia;
		b = t.ib;
		if (t.op == OP_LOAD) begin
			cap_ox[a] = t.ox; cap_oy[a] = t.oy; cap_oz[a] = t.oz;
			cap_dx[a] = t.dx; cap_dy[a] = t.dy; cap_dz[a] = t.dz;
			cap_rs[a] = t.rs; cap_re[a] = t.re;
			return r;
		end
		px = $signed(cap_ox[b]);
		px = px - $signed(cap_ox[a]);
		py = $signed(cap_oy[b]);
		py = py - $signed(cap_oy[a]);
		pz = $signed(cap_oz[b]);
		pz = pz - $signed(cap_oz[a]);
		pd0 = dot3(px, py, pz, cap_dx[a], cap_dy[a], cap_dz[a]);
		pd1 = dot3(px, py, pz, cap_dx[b], cap_dy[b], cap_dz[b]);
		d00 = dot3(cap_dx[a], cap_dy[a], cap_dz[a], cap_dx[a], cap_dy[a], cap_dz[a]);
		d11 = dot3(cap_dx[b], cap_dy[b], cap_dz[b], cap_dx[b], cap_dy[b], cap_dz[b]);
		d01 = dot3(cap_dx[a], cap_dy[a], cap_dz[a], cap_dx[b], cap_dy[b], cap_dz[b]);
		det = d00 * d11 - d01 * d01;
		t0 = 0;
		t1 = 0;
		if (det > 0) begin
			num = pd0 * d11 - pd1 * d01;
			t0 = clamp_ratio(num, det);
		end
		if (d11 != 0) begin
			wt0 = {239'd0, t0};
			num = wt0 * d01 - (pd1 <<< 16);
			t1 = clamp_ratio(num, d11 <<< 16);
		end
		if (d00 != 0) begin
			wt1 = {239'd0, t1};
			num = wt1 * d01 + (pd0 <<< 16);
			t0 = clamp_ratio(num, d00 <<< 16);
		end
		wt0 = {239'd0, t0};
		wt1 = {239'd0, t1};
		fx = wt0 * cap_dx[a] - wt1 * cap_dx[b] - (px <<< 16);
		fy = wt0 * cap_dy[a] - wt1 * cap_dy[b] - (py <<< 16);
		fz = wt0 * cap_dz[a] - wt1 * cap_dz[b] - (pz <<< 16);
		dist2 = fx * fx + fy * fy + fz * fz;
		if (dist2[255:96] != 0)
			dist_w = 32'hFFFF_FFFF;
		else
			dist_w = 32'(floor_sqrt(dist2[95:32]));
		rsum = 64'(cap_rs[a]) * (64'd65536 - t0) + 64'(cap_re[a]) * 64'(t0)
			+ 64'(cap_rs[b]) * (64'd65536 - t1) + 64'(cap_re[b]) * 64'(t1);
		radius = rsum >> 16;
		ov = $signed(radius) - $signed({32'd0, dist_w});
		r.contact = (dist_w != 0) && (ov > 0);
		pen = 0;
		if (r.contact) begin
			ov2 = ov * ov;
			prod = {64'd0, ov2} * {96'd0, weight};
			pen = (prod[127:95] != 0) ? MAX63 : prod[94:32];
		end
		sum = {1'b0, err_acc} + {1'b0, pen};
		if (sum > {1'b0, MAX63})
			sum = {1'b0, MAX63};
		r.is_pair = 1;
		r.ta = t0;
		r.tb = t1;
		r.dist_v = dist_w;
		r.ov = ov[32:0];
		r.pen = pen;
		r.total = sum[62:0];
		r.is_total = t.last;
		err_acc = t.last ? 63'd0 : sum[62:0];
		return r;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			tx_gap <= 0;
		end else if (!(in_valid && !in_ready)) begin
			if (in_valid)
				expect_q = {expect_q, predict_penalty(cur)};
			if (tx_gap > 0) begin
				tx_gap <= tx_gap - 1;
				in_valid <= 0;
			end else if (pend_q.size() > 0 && !(pend_q[0].drain && expect_q.size() > 0)) begin
				cur <= pend_q[0];
				tx_gap <= pend_q[0].gap;
				in_valid <= 1;
				void'(pend_q.pop_front());
			end else begin
				in_valid <= 0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		penalty_res_t e;
		int nxt;
		if (!arst_n) begin
			out_ready <= 0;
			rx_wait <= 0;
			rx_hold <= 0;
		end else begin
			nxt = rx_wait;
			if (out_valid && out_ready) begin
				rx_count <= rx_count + 1;
				nxt = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
				if (expect_q.size() == 0) begin
					$display("%0t unexpected transaction: is_pair %0d", $time, is_pair);
					errors <= errors + 1;
				end else begin
					e = expect_q.pop_front();
					if ({is_pair, param_a, param_b, distance, overlap, contact, penalty,
						total_error, is_total} !== {e.is_pair, e.ta, e.tb, e.dist_v, e.ov,
						e.contact, e.pen, e.total, e.is_total}) begin
						$display("%0t mismatch expected pair %0d ta %0d tb %0d dist %0d ov %0d c %0d pen %0d tot %0d last %0d",
							$time, e.is_pair, e.ta, e.tb, e.dist_v, $signed(e.ov), e.contact,
							e.pen, e.total, e.is_total);
						$display("%0t              actual pair %0d ta %0d tb %0d dist %0d ov %0d c %0d pen %0d tot %0d last %0d",
							$time, is_pair, param_a, param_b, distance, overlap, contact,
							penalty, total_error, is_total);
						errors <= errors + 1;
					end
				end
			end
			if (out_valid && out_ready && rx_count == 120) begin
				rx_hold <= 3000;
				out_ready <= 0;
				rx_wait <= nxt;
			end else if (rx_hold > 0) begin
				rx_hold <= rx_hold - 1;
				out_ready <= 0;
				rx_wait <= nxt;
			end else if (nxt > 0) begin
				rx_wait <= nxt - 1;
				out_ready <= 0;
			end else begin
				rx_wait <= 0;
				out_ready <= 1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else if (arst_n)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout");
			$display("status: fail");
			$finish;
		end
	end

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 7))
			0: return $urandom();
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0000;
			3: return 0;
			default: return $urandom_range(0, 1) ? $urandom_range(0, 1 << 20)
				: -$urandom_range(0, 1 << 20);
		endcase
	endfunction

	function automatic logic [30:0] rand_radius();
		case ($urandom_range(0, 7))
			0: return 31'($urandom());
			1: return 31'h7FFF_FFFF;
			2: return 31'd0;
			default: return 31'($urandom_range(0, 1 << 20));
		endcase
	endfunction

	task automatic add_item(logic op, logic [5:0] ia, logic [5:0] ib, logic last,
			logic [31:0] ox, oy, oz, dx, dy, dz, logic [30:0] rs, re, bit drain);
		capsule_txn_t t;
		t.op = op; t.ia = ia; t.ib = ib; t.last = last;
		t.ox = ox; t.oy = oy; t.oz = oz; t.dx = dx; t.dy = dy; t.dz = dz;
		t.rs = rs; t.re = re;
		t.drain = drain;
		t.gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
		if (op == OP_LOAD)
			loaded[ia] = 1;
		pend_q = {pend_q, t};
	endtask

	task automatic add_load(logic [5:0] ia, logic [31:0] ox, oy, oz, dx, dy, dz,
			logic [30:0] rs, re);
		add_item(OP_LOAD, ia, 6'($urandom()), 1'($urandom()), ox, oy, oz, dx, dy, dz,
			rs, re, 0);
	endtask

	task automatic add_pair(logic [5:0] ia, logic [5:0] ib, logic last);
		add_item(OP_PAIR, ia, ib, last, $urandom(), $urandom(), $urandom(), $urandom(),
			$urandom(), $urandom(), 31'($urandom()), 31'($urandom()), 0);
	endtask

	function automatic logic [5:0] pick_loaded();
		logic [5:0] k;
		do k = 6'($urandom_range(0, CAP - 1)); while (!loaded[k]);
		return k;
	endfunction

	task automatic random_phase(int n);
		logic [5:0] a, b;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 3) == 0) begin
				add_load(6'($urandom_range(0, CAP - 1)), rand_coord(), rand_coord(),
					rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_radius(),
					rand_radius());
			end else begin
				a = pick_loaded();
				b = ($urandom_range(0, 9) == 0) ? a : pick_loaded();
				add_item(OP_PAIR, a, b, $urandom_range(0, 7) == 0, $urandom(), $urandom(),
					$urandom(), $urandom(), $urandom(), $urandom(), 31'($urandom()),
					31'($urandom()), $urandom_range(0, 60) == 0);
			end
		end
	endtask

	task automatic drain_and_config(logic [31:0] w);
		while (pend_q.size() > 0 || expect_q.size() > 0 || in_valid)
			@(posedge clk);
		repeat (5) @(posedge clk);
		cfg_we <= 1;
		cfg_wdata <= w;
		@(posedge clk);
		weight = w;
		cfg_we <= 0;
		@(posedge clk);
	endtask

	initial begin
		// directed: degenerate point, extremes, parallel segments, full radii
		add_load(0, 0, 0, 0, 0, 0, 0, 31'd65536, 31'd65536);
		add_load(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 0);
		add_load(2, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 0, 31'h7FFF_FFFF);
		add_load(3, 0, 0, 0, 32'd65536, 0, 0, 31'd32768, 31'd32768);
		add_load(4, 0, 32'd16384, 0, 32'd65536, 0, 0, 31'd32768, 31'd32768);
		add_load(63, 32'd1000, -32'd1000, 0, 0, 32'd131072, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
		add_load(5, 32'd65536, 0, 0, 0, 0, 0, 31'd131072, 31'd4096);
		add_pair(0, 0, 0);
		add_pair(3, 4, 0);
		add_pair(4, 3, 0);
		add_pair(1, 2, 0);
		add_pair(2, 1, 0);
		add_pair(0, 5, 0);
		add_pair(5, 3, 0);
		add_pair(63, 63, 0);
		add_pair(63, 0, 0);
		add_pair(1, 1, 1);
		add_pair(3, 63, 0);
		add_pair(0, 3, 1);
		add_pair(3, 3, 1);
		repeat (8) @(posedge clk);
		arst_n <= 1;
		drain_and_config(32'd0);
		random_phase(350);
		drain_and_config(32'hFFFF_FFFF);
		random_phase(350);
		drain_and_config($urandom());
		random_phase(350);
		drain_and_config(32'd65536);
		random_phase(350);
		while (pend_q.size() > 0 || expect_q.size() > 0 || in_valid)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
